// ===== sv/cdob_pkg.sv =====
// package: types and constants for the cfg depth-first walker
`default_nettype none
package cdob_pkg;
	localparam int MAX_BLOCKS_DEF = 16;
	localparam int MAX_SUCC_DEF = 2;

	localparam logic [1:0] KIND_BACK_EDGE = 2'd0;
	localparam logic [1:0] KIND_BLOCK = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	localparam logic [1:0] REG_NUM_BLOCKS = 2'd0;
	localparam logic [1:0] REG_ROOT = 2'd1;

	typedef struct packed {
		logic [3:0] from_block;
		logic [3:0] to_block;
		logic last;
	} edge_req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] block;
		logic [3:0] target;
		logic loop_header;
		logic edges_dropped;
		logic end_of_run;
	} walk_res_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_FRAME,
		ST_FRAME_WAIT,
		ST_SUCC_WAIT,
		ST_SUCC_EVAL,
		ST_BE_RD,
		ST_BE_OUT,
		ST_PO_RD,
		ST_PO_OUT,
		ST_CLEAR
	} walk_state_t;
endpackage
`default_nettype wire

// ===== sv/cdob_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none
module cdob_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/cfg_dfs_order_back_edges_unit.sv =====
// top level: edge loader and depth-first walker with back-edge and order report
//
// usage
//   edges arrive on start/edge_in, one request per cycle while busy is low.
//   a request with last set is loaded like the others and then starts the walk;
//   busy stays high until the walk, the report and the store clear are done.
//   results come out on res_valid/res for one cycle each; the receiver cannot
//   stall, so each record is simply presented once.
//   cfg_we/cfg_index/cfg_data write the block count (0) and the root block (1);
//   write them only while busy is low, they apply to the next walk.
// sequence
//   a last edge starts the walk; each walk step (one per successor tried or
//   block retired) passes the frame, frame wait, successor wait and evaluate
//   states. then each back edge and each reported block is read and output,
//   each list closing with a final read, and the clear sweeps all MAX_BLOCKS
//   entries of the per-block stores. an empty graph goes straight to the clear.
// reset
//   arst_n clears counts, colour, header marks, flags and the controller; the
//   successor, stack, order and back-edge memories need no clear.
//   per-block counts, colours and header marks are flops cleared by a sweep.
`default_nettype none
module cfg_dfs_order_back_edges_unit #(
	parameter int MAX_BLOCKS = cdob_pkg::MAX_BLOCKS_DEF,
	parameter int MAX_SUCCESSORS = cdob_pkg::MAX_SUCC_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire cdob_pkg::edge_req_t edge_in,
	output logic res_valid,
	output cdob_pkg::walk_res_t res,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [4:0] cfg_data
);
	import cdob_pkg::*;

	localparam int BW = $clog2(MAX_BLOCKS);
	localparam int SD = MAX_BLOCKS * MAX_SUCCESSORS;
	localparam int SW = $clog2(SD);
	localparam int KW = $clog2(MAX_SUCCESSORS + 1);
	localparam int TW = BW + 1;
	localparam int EW = SW + 1;

	// configuration
	logic [4:0] num_blocks_q;
	logic [3:0] root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_blocks_q <= '0;
			root_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_BLOCKS: num_blocks_q <= cfg_data;
				REG_ROOT: root_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// per-block flop state
	logic [KW-1:0] succ_cnt_q [MAX_BLOCKS];
	logic [1:0] colour_q [MAX_BLOCKS];
	logic header_q [MAX_BLOCKS];
	logic overflow_q;

	walk_state_t state_q, state_d;
	logic [TW-1:0] top_q;
	logic [TW-1:0] po_cnt_q;
	logic [EW-1:0] be_cnt_q;
	logic [EW-1:0] idx_q;
	logic [BW-1:0] cur_b_q;
	logic [KW-1:0] cur_k_q;
	logic [4:0] n_eff;

	assign n_eff = (num_blocks_q > 5'(MAX_BLOCKS)) ? 5'(MAX_BLOCKS) : num_blocks_q;

	logic accept;
	assign accept = start && !busy;
	assign busy = (state_q != ST_LOAD);

	// memories
	logic succ_we;
	logic [SW-1:0] succ_waddr, succ_raddr;
	logic [3:0] succ_rdata;
	logic stk_we;
	logic [BW-1:0] stk_waddr, stk_raddr;
	logic [BW+KW-1:0] stk_wdata, stk_rdata;
	logic po_we;
	logic [BW-1:0] po_raddr;
	logic [3:0] po_rdata;
	logic be_we;
	logic [SW-1:0] be_raddr;
	logic [7:0] be_wdata, be_rdata;

	// a push updates the parent frame first; the new frame is written in the
	// following frame cycle and forwarded, since the stack read sees old data
	logic push_q;
	logic [BW-1:0] push_b_q;
	logic [BW+KW-1:0] push_frame;
	logic [BW-1:0] push_addr;
	assign push_frame = {push_b_q, KW'(0)};
	assign push_addr = BW'(top_q - TW'(1));

	cdob_ram #(.WIDTH(4), .DEPTH(SD)) u_succ (
		.clk(clk), .we(succ_we), .waddr(succ_waddr), .wdata(edge_in.to_block),
		.raddr(succ_raddr), .rdata(succ_rdata));
	cdob_ram #(.WIDTH(BW+KW), .DEPTH(MAX_BLOCKS)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata));
	cdob_ram #(.WIDTH(4), .DEPTH(MAX_BLOCKS)) u_po (
		.clk(clk), .we(po_we), .waddr(po_cnt_q[BW-1:0]), .wdata(4'(cur_b_q)),
		.raddr(po_raddr), .rdata(po_rdata));
	cdob_ram #(.WIDTH(8), .DEPTH(SD)) u_be (
		.clk(clk), .we(be_we), .waddr(be_cnt_q[SW-1:0]), .wdata(be_wdata),
		.raddr(be_raddr), .rdata(be_rdata));

	// edge load
	logic [BW-1:0] from_idx;
	logic from_ok;
	assign from_idx = edge_in.from_block[BW-1:0];
	assign from_ok = (5'(edge_in.from_block) < 5'(MAX_BLOCKS));
	logic load_ok;
	assign load_ok = accept && from_ok && (succ_cnt_q[from_idx] < KW'(MAX_SUCCESSORS));
	assign succ_we = load_ok;
	assign succ_waddr = SW'(from_idx * MAX_SUCCESSORS) + SW'(succ_cnt_q[from_idx]);

	// walk step evaluation
	logic [3:0] s_val;
	logic [BW-1:0] s_idx;
	logic s_in;
	assign s_val = succ_rdata;
	assign s_idx = s_val[BW-1:0];
	assign s_in = (5'(s_val) < n_eff);
	logic has_succ;
	assign has_succ = (cur_k_q < succ_cnt_q[cur_b_q]) && (cur_k_q < KW'(MAX_SUCCESSORS));
	logic do_push;
	assign do_push = s_in && colour_q[s_idx] == 2'd0 && top_q < TW'(MAX_BLOCKS);
	logic do_back;
	assign do_back = s_in && colour_q[s_idx] == 2'd1;
	logic empty_graph;
	assign empty_graph = (n_eff == 5'd0) || (5'(root_q) >= n_eff);

	assign succ_raddr = SW'(cur_b_q * MAX_SUCCESSORS) + SW'(cur_k_q);
	assign stk_raddr = BW'(top_q - TW'(1));
	assign be_raddr = idx_q[SW-1:0];
	assign po_raddr = BW'(po_cnt_q - TW'(1) - TW'(idx_q));
	assign be_wdata = {4'(cur_b_q), s_val};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: if (accept && edge_in.last) state_d = empty_graph ? ST_CLEAR : ST_FRAME;
			ST_FRAME: state_d = (top_q == '0) ? ST_BE_RD : ST_FRAME_WAIT;
			ST_FRAME_WAIT: state_d = ST_SUCC_WAIT;
			ST_SUCC_WAIT: state_d = ST_SUCC_EVAL;
			ST_SUCC_EVAL: state_d = ST_FRAME;
			ST_BE_RD: state_d = (idx_q == be_cnt_q) ? ST_PO_RD : ST_BE_OUT;
			ST_BE_OUT: state_d = ST_BE_RD;
			ST_PO_RD: state_d = (idx_q == EW'(po_cnt_q)) ? ST_CLEAR : ST_PO_OUT;
			ST_PO_OUT: state_d = ST_PO_RD;
			ST_CLEAR: if (idx_q == EW'(MAX_BLOCKS - 1)) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	// memory writes and result outputs
	always_comb begin
		stk_we = 1'b0;
		stk_waddr = '0;
		stk_wdata = '0;
		po_we = 1'b0;
		be_we = 1'b0;
		res_valid = 1'b0;
		res = '0;
		res.edges_dropped = overflow_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && edge_in.last && !empty_graph) begin
					stk_we = 1'b1;
					stk_wdata = {root_q[BW-1:0], KW'(0)};
				end
			end
			ST_FRAME: begin
				if (push_q) begin
					stk_we = 1'b1;
					stk_waddr = push_addr;
					stk_wdata = push_frame;
				end
			end
			ST_SUCC_EVAL: begin
				if (has_succ) begin
					stk_we = 1'b1;
					stk_waddr = BW'(top_q - TW'(1));
					stk_wdata = {cur_b_q, KW'(cur_k_q + KW'(1))};
					be_we = do_back && be_cnt_q < EW'(SD);
				end else begin
					po_we = po_cnt_q < TW'(MAX_BLOCKS);
				end
			end
			ST_BE_OUT: begin
				res_valid = 1'b1;
				res.kind = KIND_BACK_EDGE;
				res.block = be_rdata[7:4];
				res.target = be_rdata[3:0];
			end
			ST_PO_OUT: begin
				res_valid = 1'b1;
				res.kind = KIND_BLOCK;
				res.block = po_rdata;
				res.target = 4'(idx_q);
				res.loop_header = header_q[po_rdata[BW-1:0]];
				res.end_of_run = (idx_q + EW'(1) == EW'(po_cnt_q));
			end
			ST_CLEAR: begin
				if (idx_q == '0 && po_cnt_q == '0) begin
					res_valid = 1'b1;
					res.kind = KIND_EMPTY;
					res.end_of_run = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			top_q <= '0;
			po_cnt_q <= '0;
			be_cnt_q <= '0;
			idx_q <= '0;
			cur_b_q <= '0;
			cur_k_q <= '0;
			overflow_q <= 1'b0;
			push_q <= 1'b0;
			push_b_q <= '0;
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				succ_cnt_q[i] <= '0;
				colour_q[i] <= '0;
				header_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					idx_q <= '0;
					if (accept) begin
						if (from_ok) begin
							if (load_ok) begin
								succ_cnt_q[from_idx] <= succ_cnt_q[from_idx] + KW'(1);
							end else begin
								overflow_q <= 1'b1;
							end
						end
						if (edge_in.last && !empty_graph) begin
							colour_q[root_q[BW-1:0]] <= 2'd1;
							top_q <= TW'(1);
						end
					end
				end
				ST_FRAME: idx_q <= '0;
				ST_FRAME_WAIT: begin
					// a frame pushed one step ago is taken from the push registers
					cur_b_q <= push_q ? push_b_q : stk_rdata[BW+KW-1:KW];
					cur_k_q <= push_q ? KW'(0) : stk_rdata[KW-1:0];
					push_q <= 1'b0;
				end
				ST_SUCC_EVAL: begin
					if (has_succ) begin
						if (do_back) begin
							header_q[s_idx] <= 1'b1;
							if (be_cnt_q < EW'(SD)) be_cnt_q <= be_cnt_q + EW'(1);
						end else if (do_push) begin
							colour_q[s_idx] <= 2'd1;
							push_q <= 1'b1;
							push_b_q <= s_idx;
							top_q <= top_q + TW'(1);
						end
					end else begin
						colour_q[cur_b_q] <= 2'd2;
						if (po_cnt_q < TW'(MAX_BLOCKS)) po_cnt_q <= po_cnt_q + TW'(1);
						top_q <= top_q - TW'(1);
					end
				end
				ST_BE_RD: if (idx_q == be_cnt_q) idx_q <= '0;
				ST_BE_OUT: idx_q <= idx_q + EW'(1);
				ST_PO_RD: if (idx_q == EW'(po_cnt_q)) idx_q <= '0;
				ST_PO_OUT: idx_q <= idx_q + EW'(1);
				ST_CLEAR: begin
					succ_cnt_q[idx_q[BW-1:0]] <= '0;
					colour_q[idx_q[BW-1:0]] <= '0;
					header_q[idx_q[BW-1:0]] <= 1'b0;
					idx_q <= idx_q + EW'(1);
					if (idx_q == EW'(MAX_BLOCKS - 1)) begin
						top_q <= '0;
						po_cnt_q <= '0;
						be_cnt_q <= '0;
						overflow_q <= 1'b0;
						idx_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire
